// ----- rtl/core/crfmn_pkg.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// crfmn_pkg: shared types and tables of the chain-CRF normalizer
// Transfer payload structs, opcodes, state encoding and the exp/ln tables.
// ----------------------------------------------------------------------------
package crfmn_pkg;

	localparam int MAX_TAGS   = 64;
	localparam int SCORE_BITS = 24;
	localparam int TAG_W      = $clog2(MAX_TAGS);
	localparam int CNT_W      = $clog2(MAX_TAGS + 1);
	localparam int ROW_W      = SCORE_BITS + 1;
	localparam int D_W        = ROW_W + 1;
	localparam int V_W        = 25;
	localparam int SUM_W      = V_W + TAG_W;
	localparam int LN_W       = 16;
	localparam int LL_W       = 32;
	localparam int NSH_W      = $clog2(TAG_W + 1);
	localparam int LN2_Q16    = 45426;
	localparam int EXP_STEPS  = 12;
	localparam int LN_STEPS   = 14;

	typedef enum logic [1:0] {
		OP_START  = 2'd0,
		OP_PATH   = 2'd1,
		OP_MARG   = 2'd2,
		OP_FINISH = 2'd3
	} opcode_t;

	typedef enum logic {
		KIND_MARG = 1'b0,
		KIND_LL   = 1'b1
	} kind_t;

	typedef struct packed {
		opcode_t                       opcode;
		logic signed [SCORE_BITS-1:0]  forward_score;
		logic signed [SCORE_BITS-1:0]  backward_score;
		logic signed [SCORE_BITS-1:0]  path_score;
		logic                          row_end;
	} in_item_t;

	typedef struct packed {
		kind_t                  kind;
		logic [5:0]             tag_index;
		logic [16:0]            marginal;
		logic signed [LL_W-1:0] loglik;
		logic                   final_item;
	} out_item_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_SUM_RD,
		ST_SUM_GO,
		ST_SUM_WAIT,
		ST_LN_NORM,
		ST_LN_STEP,
		ST_LN_FIN,
		ST_LSE,
		ST_MRG_RD,
		ST_MRG_GO,
		ST_MRG_WAIT,
		ST_MRG_EMIT
	} state_t;

	// exp(-k), Q.24
	function automatic logic [V_W-1:0] exp_int(input logic [3:0] k);
		logic [V_W-1:0] r;
		unique case (k)
			4'd0:    r = 25'd16777216;
			4'd1:    r = 25'd6171993;
			4'd2:    r = 25'd2270549;
			4'd3:    r = 25'd835288;
			4'd4:    r = 25'd307285;
			4'd5:    r = 25'd113044;
			4'd6:    r = 25'd41587;
			4'd7:    r = 25'd15299;
			4'd8:    r = 25'd5628;
			4'd9:    r = 25'd2070;
			4'd10:   r = 25'd762;
			4'd11:   r = 25'd280;
			default: r = '0;
		endcase
		return r;
	endfunction

	// exp(-2^-(j+1)), Q.24
	function automatic logic [23:0] exp_frac(input logic [3:0] j);
		logic [23:0] r;
		unique case (j)
			4'd0:    r = 24'd10175896;
			4'd1:    r = 24'd13066109;
			4'd2:    r = 24'd14805841;
			4'd3:    r = 24'd15760736;
			4'd4:    r = 24'd16261035;
			4'd5:    r = 24'd16517109;
			4'd6:    r = 24'd16646655;
			4'd7:    r = 24'd16711808;
			4'd8:    r = 24'd16744480;
			4'd9:    r = 24'd16760840;
			4'd10:   r = 24'd16769026;
			4'd11:   r = 24'd16773121;
			default: r = '0;
		endcase
		return r;
	endfunction

	// ln(1 + 2^-j), Q.16, j = 1..14
	function automatic logic [14:0] ln_step(input logic [3:0] j);
		logic [14:0] r;
		unique case (j)
			4'd1:    r = 15'd26573;
			4'd2:    r = 15'd14624;
			4'd3:    r = 15'd7719;
			4'd4:    r = 15'd3973;
			4'd5:    r = 15'd2017;
			4'd6:    r = 15'd1016;
			4'd7:    r = 15'd510;
			4'd8:    r = 15'd255;
			4'd9:    r = 15'd128;
			4'd10:   r = 15'd64;
			4'd11:   r = 15'd32;
			4'd12:   r = 15'd16;
			4'd13:   r = 15'd8;
			4'd14:   r = 15'd4;
			default: r = '0;
		endcase
		return r;
	endfunction

endpackage
`default_nettype wire

// ----- rtl/core/crfmn_exp.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// crfmn_exp: iterative exp(-d) unit
// Integer part from a table, then one rounded Q.24 multiply per set fraction bit.
// ----------------------------------------------------------------------------
module crfmn_exp (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire logic                        start,
	input  wire logic [crfmn_pkg::D_W-1:0]   d,
	output logic                             done,
	output logic [crfmn_pkg::V_W-1:0]        v
);

	logic                          busy_q;
	logic                          done_q;
	logic [3:0]                    j_q;
	logic [11:0]                   f_q;
	logic [crfmn_pkg::V_W-1:0]     v_q;
	logic [crfmn_pkg::D_W-13:0]    k;
	logic [48:0]                   prod;
	logic [48:0]                   rnd;

	assign k    = d[crfmn_pkg::D_W-1:12];
	assign prod = 49'(v_q) * 49'(crfmn_pkg::exp_frac(j_q));
	assign rnd  = prod + 49'(1 << 23);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			j_q    <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				j_q <= '0;
				if (k >= (crfmn_pkg::D_W-12)'(crfmn_pkg::EXP_STEPS)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end else begin
					busy_q <= 1'b1;
				end
			end else if (busy_q) begin
				j_q <= j_q + 4'd1;
				if (j_q == 4'(crfmn_pkg::EXP_STEPS - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			f_q <= d[11:0];
			if (k >= (crfmn_pkg::D_W-12)'(crfmn_pkg::EXP_STEPS))
				v_q <= '0;
			else
				v_q <= crfmn_pkg::exp_int(k[3:0]);
		end else if (busy_q) begin
			f_q <= {f_q[10:0], 1'b0};
			if (f_q[11])
				v_q <= rnd[48:24];
		end
	end

	assign done = done_q;
	assign v    = v_q;

endmodule
`default_nettype wire

// ----- rtl/core/crf_marginal_normalizer_top.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// crf_marginal_normalizer_top: chain-CRF log-likelihood seed and marginals
// Stores a row of scores, forms its log-sum-exp and emits marginals or the
// log-likelihood from a saturating accumulator.
// ----------------------------------------------------------------------------
//
//  Channel | Signals                     | Payload
//  --------+-----------------------------+---------------------------------
//  input   | in_valid, in_ready          | in_data  (crfmn_pkg::in_item_t)
//  output  | out_valid, out_ready        | out_data (crfmn_pkg::out_item_t)
//
// Any item is taken while the block is idle and the output
// register is free; a result still waiting in that register holds the input.
// A row end runs a sum pass over the row memory through the exp unit, then
// the log; a marginal row then runs a second pass that emits one marginal
// per stored tag and can wait on a stall of the output side. The exp unit
// skips its iterations for a tag 12 or more below the row maximum.
// The memory has one port, and the exp unit iterates over 12 fraction bits.
// Reset clears the row count, the row maximum and the accumulator; the row
// memory needs no clearing since only entries written in this row are read.
// ----------------------------------------------------------------------------
module crf_marginal_normalizer_top (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  in_valid,
	output logic                       in_ready,
	input  wire crfmn_pkg::in_item_t   in_data,
	output logic                       out_valid,
	input  wire logic                  out_ready,
	output crfmn_pkg::out_item_t       out_data
);

	localparam int ROW_W = crfmn_pkg::ROW_W;
	localparam int SB    = crfmn_pkg::SCORE_BITS;

	crfmn_pkg::state_t state_q, state_d;

	// Row state.
	logic [crfmn_pkg::CNT_W-1:0]   cnt_q;
	logic [crfmn_pkg::CNT_W-1:0]   idx_q;
	logic signed [ROW_W-1:0]       rmax_q;
	logic                          row_marg_q;
	logic signed [31:0]            acc_q;

	// Row memory, one synchronous port.
	logic [ROW_W-1:0]              mem [crfmn_pkg::MAX_TAGS];
	logic signed [ROW_W-1:0]       rd_s1;

	// Log-sum-exp datapath.
	logic [crfmn_pkg::SUM_W-1:0]   sum_q;
	logic [crfmn_pkg::V_W:0]       lnx_q;
	logic [crfmn_pkg::NSH_W-1:0]   lnn_q;
	logic [16:0]                   lnacc_q;
	logic [3:0]                    lnj_q;
	logic [crfmn_pkg::LN_W-1:0]    ln12_q;
	logic signed [ROW_W:0]         lse_q;
	logic [crfmn_pkg::V_W-1:0]     mv_q;

	crfmn_pkg::out_item_t          out_q;
	logic                          out_valid_q;

	logic                          in_fire;
	logic                          out_free;
	logic                          out_load;
	logic                          is_elem;
	logic signed [ROW_W-1:0]       elem;
	logic signed [32:0]            path_sum;
	logic                          exp_start;
	logic [crfmn_pkg::D_W-1:0]     exp_d;
	logic                          exp_done;
	logic [crfmn_pkg::V_W-1:0]     exp_v;
	logic                          last_idx;
	logic [crfmn_pkg::SUM_W-1:0]   sumc;
	logic [crfmn_pkg::NSH_W-1:0]   nsh;
	logic [crfmn_pkg::V_W:0]       lnt;
	logic signed [18:0]            lnm;
	logic [19:0]                   total;
	logic [ROW_W:0]                lse_d;
	logic [ROW_W+1:0]              mrg_d;
	logic [crfmn_pkg::V_W:0]       mrnd;

	assign out_free = !out_valid_q || out_ready;
	assign in_ready = (state_q == crfmn_pkg::ST_IDLE) && out_free;
	assign in_fire  = in_valid && in_ready;
	assign is_elem  = (in_data.opcode == crfmn_pkg::OP_START) ||
	                  (in_data.opcode == crfmn_pkg::OP_MARG);
	assign last_idx = (idx_q + crfmn_pkg::CNT_W'(1)) == cnt_q;

	// The output register is loaded by a finish item or by a marginal emit.
	assign out_load = (in_fire && (in_data.opcode == crfmn_pkg::OP_FINISH)) ||
	                  ((state_q == crfmn_pkg::ST_MRG_EMIT) && out_free);

	always_comb begin
		if (in_data.opcode == crfmn_pkg::OP_MARG)
			elem = ROW_W'(in_data.forward_score) + ROW_W'(in_data.backward_score);
		else
			elem = ROW_W'(in_data.backward_score);
	end

	assign path_sum = 33'(acc_q) + 33'(in_data.path_score);

	// Normalize the exp sum to [1, 2) in Q.24.
	always_comb begin
		sumc = sum_q;
		if (sum_q < crfmn_pkg::SUM_W'(1 << 24))
			sumc = crfmn_pkg::SUM_W'(1 << 24);
		nsh = '0;
		for (int b = 1; b <= crfmn_pkg::TAG_W; b++) begin
			if (sumc[24 + b])
				nsh = crfmn_pkg::NSH_W'(b);
		end
	end

	assign lnt   = lnx_q + (lnx_q >> lnj_q);
	assign lnm   = 19'(crfmn_pkg::LN2_Q16) - 19'(lnacc_q);
	assign total = 20'(lnn_q) * 20'(crfmn_pkg::LN2_Q16)
	             + ((lnm < 0) ? 20'd0 : 20'(lnm));
	assign lse_d = {rmax_q[ROW_W-1], rmax_q} + (ROW_W+1)'(ln12_q);
	assign mrg_d = {lse_q[ROW_W], lse_q} - (ROW_W+2)'(rd_s1);
	assign mrnd  = {1'b0, mv_q} + (crfmn_pkg::V_W+1)'(128);

	always_comb begin
		exp_start = 1'b0;
		exp_d     = '0;
		if (state_q == crfmn_pkg::ST_SUM_GO) begin
			exp_start = 1'b1;
			exp_d     = crfmn_pkg::D_W'(rmax_q) - crfmn_pkg::D_W'(rd_s1);
		end else if (state_q == crfmn_pkg::ST_MRG_GO) begin
			exp_start = 1'b1;
			exp_d     = mrg_d[crfmn_pkg::D_W-1:0];
		end
	end

	crfmn_exp u_exp (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (exp_start),
		.d      (exp_d),
		.done   (exp_done),
		.v      (exp_v)
	);

	// Next state.
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			crfmn_pkg::ST_IDLE:
				if (in_fire && is_elem && in_data.row_end)
					state_d = crfmn_pkg::ST_SUM_RD;
			crfmn_pkg::ST_SUM_RD:   state_d = crfmn_pkg::ST_SUM_GO;
			crfmn_pkg::ST_SUM_GO:   state_d = crfmn_pkg::ST_SUM_WAIT;
			crfmn_pkg::ST_SUM_WAIT:
				if (exp_done)
					state_d = last_idx ? crfmn_pkg::ST_LN_NORM : crfmn_pkg::ST_SUM_RD;
			crfmn_pkg::ST_LN_NORM:  state_d = crfmn_pkg::ST_LN_STEP;
			crfmn_pkg::ST_LN_STEP:
				if (lnj_q == 4'(crfmn_pkg::LN_STEPS))
					state_d = crfmn_pkg::ST_LN_FIN;
			crfmn_pkg::ST_LN_FIN:   state_d = crfmn_pkg::ST_LSE;
			crfmn_pkg::ST_LSE:
				state_d = row_marg_q ? crfmn_pkg::ST_MRG_RD : crfmn_pkg::ST_IDLE;
			crfmn_pkg::ST_MRG_RD:   state_d = crfmn_pkg::ST_MRG_GO;
			crfmn_pkg::ST_MRG_GO:   state_d = crfmn_pkg::ST_MRG_WAIT;
			crfmn_pkg::ST_MRG_WAIT:
				if (exp_done)
					state_d = crfmn_pkg::ST_MRG_EMIT;
			crfmn_pkg::ST_MRG_EMIT:
				if (out_free)
					state_d = last_idx ? crfmn_pkg::ST_IDLE : crfmn_pkg::ST_MRG_RD;
			default:                state_d = crfmn_pkg::ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			state_q <= crfmn_pkg::ST_IDLE;
		else
			state_q <= state_d;
	end

	// Control registers: row count, row maximum, accumulator, output valid.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q       <= '0;
			rmax_q      <= -(ROW_W'(1) <<< SB);
			acc_q       <= '0;
			out_valid_q <= 1'b0;
			row_marg_q  <= 1'b0;
			idx_q       <= '0;
		end else begin
			if (out_load)
				out_valid_q <= 1'b1;
			else if (out_ready)
				out_valid_q <= 1'b0;
			unique case (state_q)
				crfmn_pkg::ST_IDLE:
					if (in_fire) begin
						if (is_elem) begin
							if (cnt_q < crfmn_pkg::CNT_W'(crfmn_pkg::MAX_TAGS)) begin
								cnt_q <= cnt_q + crfmn_pkg::CNT_W'(1);
								if (elem > rmax_q)
									rmax_q <= elem;
							end
							row_marg_q <= (in_data.opcode == crfmn_pkg::OP_MARG);
							idx_q      <= '0;
						end else if (in_data.opcode == crfmn_pkg::OP_PATH) begin
							if (path_sum[32] != path_sum[31])
								acc_q <= path_sum[32] ? 32'sh8000_0000 : 32'sh7FFF_FFFF;
							else
								acc_q <= path_sum[31:0];
						end
					end
				crfmn_pkg::ST_SUM_WAIT:
					if (exp_done)
						idx_q <= last_idx ? '0 : idx_q + crfmn_pkg::CNT_W'(1);
				crfmn_pkg::ST_LSE:
					if (!row_marg_q) begin
						acc_q  <= -(32'(signed'(lse_d)));
						cnt_q  <= '0;
						rmax_q <= -(ROW_W'(1) <<< SB);
					end
				crfmn_pkg::ST_MRG_EMIT:
					if (out_free) begin
						idx_q <= idx_q + crfmn_pkg::CNT_W'(1);
						if (last_idx) begin
							cnt_q  <= '0;
							rmax_q <= -(ROW_W'(1) <<< SB);
						end
					end
				default: ;
			endcase
		end
	end

	// Row memory: written on each stored element, read every cycle.
	always_ff @(posedge clk) begin
		if (in_fire && is_elem && cnt_q < crfmn_pkg::CNT_W'(crfmn_pkg::MAX_TAGS))
			mem[cnt_q[crfmn_pkg::TAG_W-1:0]] <= elem;
		rd_s1 <= mem[idx_q[crfmn_pkg::TAG_W-1:0]];
	end

	// Datapath registers.
	always_ff @(posedge clk) begin
		unique case (state_q)
			crfmn_pkg::ST_IDLE: begin
				sum_q <= '0;
				if (in_fire && in_data.opcode == crfmn_pkg::OP_FINISH) begin
					out_q.kind       <= crfmn_pkg::KIND_LL;
					out_q.tag_index  <= '0;
					out_q.marginal   <= '0;
					out_q.loglik     <= acc_q;
					out_q.final_item <= 1'b1;
				end
			end
			crfmn_pkg::ST_SUM_WAIT:
				if (exp_done)
					sum_q <= sum_q + crfmn_pkg::SUM_W'(exp_v);
			crfmn_pkg::ST_LN_NORM: begin
				lnn_q   <= nsh;
				lnx_q   <= (crfmn_pkg::V_W+1)'(sumc >> nsh);
				lnacc_q <= '0;
				lnj_q   <= 4'd1;
			end
			crfmn_pkg::ST_LN_STEP: begin
				if (lnt <= (crfmn_pkg::V_W+1)'(1 << 25)) begin
					lnx_q   <= lnt;
					lnacc_q <= lnacc_q + 17'(crfmn_pkg::ln_step(lnj_q));
				end
				lnj_q <= lnj_q + 4'd1;
			end
			crfmn_pkg::ST_LN_FIN:
				ln12_q <= crfmn_pkg::LN_W'((total + 20'd8) >> 4);
			crfmn_pkg::ST_LSE:
				lse_q <= lse_d;
			crfmn_pkg::ST_MRG_WAIT:
				if (exp_done)
					mv_q <= exp_v;
			crfmn_pkg::ST_MRG_EMIT:
				if (out_free) begin
					out_q.kind       <= crfmn_pkg::KIND_MARG;
					out_q.tag_index  <= 6'(idx_q);
					out_q.marginal   <= mrnd[24:8];
					out_q.loglik     <= '0;
					out_q.final_item <= last_idx;
				end
			default: ;
		endcase
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_q;

	// The input side is only open while no row pass runs.
	a_ready_idle: assert property (@(posedge clk) disable iff (!arst_n)
		in_ready |-> state_q == crfmn_pkg::ST_IDLE)
		else $error("input ready outside idle");

	a_cnt_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= crfmn_pkg::CNT_W'(crfmn_pkg::MAX_TAGS))
		else $error("row count beyond capacity");

	a_exp_done: assert property (@(posedge clk) disable iff (!arst_n)
		exp_done |-> (state_q == crfmn_pkg::ST_SUM_WAIT ||
		              state_q == crfmn_pkg::ST_MRG_WAIT))
		else $error("exp result arrived with no waiting pass");

	a_emit: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == crfmn_pkg::ST_MRG_EMIT && out_free) |=>
		(out_valid_q && out_q.kind == crfmn_pkg::KIND_MARG))
		else $error("marginal not presented after emit");

endmodule
`default_nettype wire

// ----- test/tb_crf_marginal_normalizer_top.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_crf_marginal_normalizer_top: self-checking bench of the CRF normalizer
// Drives start rows, path potentials, marginal rows and finish items through
// the input channel, predicts every marginal and log-likelihood result in
// fixed point, and compares the output stream field by field.
// ----------------------------------------------------------------------------
module tb_crf_marginal_normalizer_top;

	// Predicts the block and holds the results still owed by the output.
	class crf_scoreboard;
		crfmn_pkg::out_item_t owed[$];
		longint row_vals[64];
		longint row_peak;
		int unsigned row_len;
		longint ll_acc;
		int unsigned n_errors;
		int unsigned n_checked;

		function void clear_row();
			row_len = 0;
			row_peak = -(longint'(1) << crfmn_pkg::SCORE_BITS);
		endfunction

		function void reset_state();
			clear_row();
			ll_acc = 0;
			owed.delete();
		endfunction

		function longint clamp32(longint v);
			if (v > 64'sd2147483647)
				return 64'sd2147483647;
			if (v < -64'sd2147483648)
				return -64'sd2147483648;
			return v;
		endfunction

		// exp(-d) for d >= 0, d in Q.12, result in Q.24.
		function longint exp_neg(longint d);
			longint k;
			longint fr;
			longint v;
			longint int_tab[12];
			longint frac_tab[12];
			int_tab = '{16777216, 6171993, 2270549, 835288, 307285, 113044,
				41587, 15299, 5628, 2070, 762, 280};
			frac_tab = '{10175896, 13066109, 14805841, 15760736, 16261035,
				16517109, 16646655, 16711808, 16744480, 16760840, 16769026,
				16773121};
			k = d >>> 12;
			fr = d & 'hFFF;
			if (k >= 12)
				return 0;
			v = int_tab[k];
			for (int j = 0; j < 12; j++)
				if ((fr >> (11 - j)) & 1)
					v = (v * frac_tab[j] + 64'd8388608) >> 24;
			return v;
		endfunction

		// Natural log of a Q.24 sum (>= 1.0), returned in Q.12.
		function longint ln_of_sum(longint s);
			int n;
			longint x;
			longint t;
			longint acc;
			longint lnm;
			longint step_tab[14];
			step_tab = '{26573, 14624, 7719, 3973, 2017, 1016, 510, 255, 128,
				64, 32, 16, 8, 4};
			n = 0;
			acc = 0;
			while ((s >> n) >= 2 * 64'd16777216 && n < 40)
				n++;
			x = s >> n;
			for (int j = 1; j <= 14; j++) begin
				t = x + (x >> j);
				if (t <= 2 * 64'd16777216) begin
					x = t;
					acc += step_tab[j - 1];
				end
			end
			lnm = crfmn_pkg::LN2_Q16 - acc;
			if (lnm < 0)
				lnm = 0;
			return (n * crfmn_pkg::LN2_Q16 + lnm + 8) >>> 4;
		endfunction

		function longint row_log_sum_exp();
			longint s;
			s = 0;
			for (int i = 0; i < row_len; i++)
				s += exp_neg(row_peak - row_vals[i]);
			if (s < 64'd16777216)
				s = 64'd16777216;
			return row_peak + ln_of_sum(s);
		endfunction

		function void keep_element(longint v);
			if (row_len < 64) begin
				row_vals[row_len] = v;
				row_len++;
				if (v > row_peak)
					row_peak = v;
			end
		endfunction

		// Note one accepted input transfer and queue the results it causes.
		function void note_input(crfmn_pkg::in_item_t it);
			crfmn_pkg::out_item_t r;
			longint lse;
			longint e;
			unique case (it.opcode)
				crfmn_pkg::OP_PATH: ll_acc = clamp32(ll_acc + longint'(it.path_score));
				crfmn_pkg::OP_FINISH: begin
					r = '0;
					r.kind = crfmn_pkg::KIND_LL;
					r.loglik = ll_acc[31:0];
					r.final_item = 1'b1;
					owed.push_back(r);
				end
				crfmn_pkg::OP_START: begin
					keep_element(longint'(it.backward_score));
					if (it.row_end) begin
						ll_acc = clamp32(-row_log_sum_exp());
						clear_row();
					end
				end
				default: begin
					keep_element(longint'(it.forward_score) +
						longint'(it.backward_score));
					if (it.row_end) begin
						lse = row_log_sum_exp();
						for (int i = 0; i < row_len; i++) begin
							e = exp_neg(lse - row_vals[i]);
							r = '0;
							r.kind = crfmn_pkg::KIND_MARG;
							r.tag_index = i[5:0];
							r.marginal = 17'((e + 128) >> 8);
							r.final_item = (i + 1 == row_len);
							owed.push_back(r);
						end
						clear_row();
					end
				end
			endcase
		endfunction

		// Compare one accepted output transfer with the oldest expectation.
		function void check_output(crfmn_pkg::out_item_t got);
			crfmn_pkg::out_item_t want;
			n_checked++;
			if (owed.size() == 0) begin
				$error("unexpected result transfer: %p", got);
				n_errors++;
				return;
			end
			want = owed.pop_front();
			if (got.kind !== want.kind) begin
				$error("kind: expected %0d, got %0d", want.kind, got.kind);
				n_errors++;
			end
			if (got.tag_index !== want.tag_index) begin
				$error("tag_index: expected %0d, got %0d", want.tag_index, got.tag_index);
				n_errors++;
			end
			if (got.marginal !== want.marginal) begin
				$error("marginal: expected %0d, got %0d", want.marginal, got.marginal);
				n_errors++;
			end
			if (got.loglik !== want.loglik) begin
				$error("loglik: expected %0d, got %0d",
					want.loglik, got.loglik);
				n_errors++;
			end
			if (got.final_item !== want.final_item) begin
				$error("final_item: expected %0d, got %0d",
					want.final_item, got.final_item);
				n_errors++;
			end
		endfunction
	endclass

	logic clk;
	logic arst_n;
	logic in_valid;
	logic in_ready;
	crfmn_pkg::in_item_t in_data;
	logic out_valid;
	logic out_ready;
	crfmn_pkg::out_item_t out_data;

	crf_scoreboard sb;

	// Idling percentages for the sender and the receiver; changed per phase.
	int unsigned send_idle_pct;
	int unsigned recv_idle_pct;
	// When set, the receiver process holds ready low for a long stretch.
	bit recv_hold_req;
	int unsigned n_sent;
	longint unsigned cycle_count;

	localparam longint unsigned CYCLE_LIMIT = 64'd3000000;

	crf_marginal_normalizer_top dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.in_data   (in_data),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_data  (out_data)
	);

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	// The watchdog counts cycles and ends a hung run.
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("timeout after %0d cycles", cycle_count);
			$display("Regression FAIL");
			$finish;
		end
	end

	// The receiver samples the output at each rising edge. A result counts as
	// transferred when valid and ready were both high at that edge. The next
	// ready value is then drawn, either from the idling mix or from a
	// requested long hold-off that this process times by itself.
	initial begin : receiver
		int unsigned hold_left;
		hold_left = 0;
		forever begin
			@(posedge clk);
			if (arst_n && out_valid && out_ready)
				sb.check_output(out_data);
			if (recv_hold_req && hold_left == 0) begin
				hold_left = 400;
				recv_hold_req = 1'b0;
			end
			if (hold_left > 0) begin
				hold_left--;
				out_ready <= 1'b0;
			end else begin
				out_ready <= ($urandom_range(99) >= recv_idle_pct);
			end
		end
	end

	// Offer one item and hold it until the block takes it. Valid stays high
	// after the transfer; the next idle cycle or a drain lowers it, so back to
	// back items keep valid high without a gap.
	task automatic send_item(crfmn_pkg::in_item_t it);
		while ($urandom_range(99) < send_idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		in_data <= it;
		do
			@(posedge clk);
		while (!in_ready);
		sb.note_input(it);
		n_sent++;
	endtask

	function automatic crfmn_pkg::in_item_t make_item(crfmn_pkg::opcode_t op, int fwd,
			int bwd, int path, bit last);
		crfmn_pkg::in_item_t it;
		it.opcode = op;
		it.forward_score = fwd[crfmn_pkg::SCORE_BITS-1:0];
		it.backward_score = bwd[crfmn_pkg::SCORE_BITS-1:0];
		it.path_score = path[crfmn_pkg::SCORE_BITS-1:0];
		it.row_end = last;
		return it;
	endfunction

	// A score that is mostly near zero, sometimes anywhere in the full range.
	function automatic int rand_score();
		if ($urandom_range(9) == 0)
			return $signed($urandom()) >>> 8;
		return int'($urandom_range(40000)) - 20000;
	endfunction

	// One row of start or marginal elements with random content. Other item
	// kinds may be mixed into the row, with a random row_end flag.
	task automatic send_row(crfmn_pkg::opcode_t op, int unsigned n_tags, bit mixed);
		int unsigned sel;
		for (int i = 0; i < n_tags; i++) begin
			if (mixed && $urandom_range(5) == 0) begin
				sel = $urandom_range(1);
				send_item(make_item(sel ? crfmn_pkg::OP_PATH : crfmn_pkg::OP_START,
					rand_score(), rand_score(), rand_score(), $urandom_range(1)));
			end
			send_item(make_item(op, rand_score(), rand_score(), rand_score(),
				i == n_tags - 1));
		end
	endtask

	// Stop offering, let the block finish every owed result, then a few spare
	// cycles.
	task automatic drain();
		in_valid <= 1'b0;
		while (sb.owed.size() != 0)
			@(posedge clk);
		repeat (40) @(posedge clk);
	endtask

	// Random phase: mostly well formed sentences (start row, path items,
	// marginal rows, finish) with random content, plus some noise.
	task automatic random_phase(int unsigned n_items);
		int unsigned goal;
		int unsigned pick;
		goal = n_sent + n_items;
		while (n_sent < goal) begin
			pick = $urandom_range(99);
			if (pick < 15)
				send_row(crfmn_pkg::OP_START, $urandom_range(1, 6), 1'b0);
			else if (pick < 35)
				send_item(make_item(crfmn_pkg::OP_PATH, rand_score(), rand_score(),
					rand_score(), $urandom_range(1)));
			else if (pick < 75)
				send_row(crfmn_pkg::OP_MARG, ($urandom_range(19) == 0) ?
					$urandom_range(20, 64) : $urandom_range(1, 6),
					$urandom_range(3) == 0);
			else if (pick < 90)
				send_item(make_item(crfmn_pkg::OP_FINISH, rand_score(), rand_score(),
					rand_score(), $urandom_range(1)));
			else
				send_item(make_item(crfmn_pkg::opcode_t'($urandom_range(3)), $urandom(),
					$urandom(), $urandom(), 1'b0));
		end
	endtask

	initial begin : stimulus
		sb = new();
		sb.reset_state();
		sb.n_errors = 0;
		sb.n_checked = 0;
		cycle_count = 0;
		n_sent = 0;
		recv_hold_req = 1'b0;
		send_idle_pct = 0;
		recv_idle_pct = 0;
		in_valid = 1'b0;
		in_data = '0;
		out_ready = 1'b0;
		arst_n = 1'b0;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed part: finish on reset state, the score extremes, a start
		// row, path items at both score extremes, a single-tag row, a mixed
		// row decided by its last element, row_end on path and finish, and a
		// row that overflows the tag store.
		send_item(make_item(crfmn_pkg::OP_FINISH, 0, 0, 0, 1'b1));
		send_item(make_item(crfmn_pkg::OP_START, 0, 8388607, 0, 1'b0));
		send_item(make_item(crfmn_pkg::OP_START, 0, -8388608, 0, 1'b1));
		send_item(make_item(crfmn_pkg::OP_FINISH, 0, 0, 0, 1'b0));
		for (int i = 0; i < 4; i++)
			send_item(make_item(crfmn_pkg::OP_PATH, 0, 0, -8388608, 1'b1));
		for (int i = 0; i < 4; i++)
			send_item(make_item(crfmn_pkg::OP_PATH, 0, 0, 8388607, 1'b0));
		send_item(make_item(crfmn_pkg::OP_FINISH, 0, 0, 0, 1'b0));
		send_item(make_item(crfmn_pkg::OP_FINISH, -1, -1, -1, 1'b1));
		send_item(make_item(crfmn_pkg::OP_MARG, 8388607, 8388607, 0, 1'b1));
		send_item(make_item(crfmn_pkg::OP_MARG, -8388608, -8388608, 0, 1'b0));
		send_item(make_item(crfmn_pkg::OP_MARG, 8388607, 8388607, 0, 1'b0));
		send_item(make_item(crfmn_pkg::OP_MARG, 0, 0, 0, 1'b1));
		send_item(make_item(crfmn_pkg::OP_MARG, 100, 200, 0, 1'b0));
		send_item(make_item(crfmn_pkg::OP_START, 0, 300, 0, 1'b0));
		send_item(make_item(crfmn_pkg::OP_MARG, 0, 0, 0, 1'b1));
		send_item(make_item(crfmn_pkg::OP_MARG, 4096, 0, 0, 1'b0));
		send_item(make_item(crfmn_pkg::OP_START, 0, 0, 0, 1'b1));
		send_row(crfmn_pkg::OP_MARG, 66, 1'b0);
		send_item(make_item(crfmn_pkg::OP_FINISH, 0, 0, 0, 1'b0));
		drain();

		// Random phase one, with one long receiver hold-off mid-way so the
		// block fills up and stalls its input.
		send_idle_pct = 30;
		recv_idle_pct = 55;
		random_phase(50);
		recv_hold_req = 1'b1;
		random_phase(50);
		// The sender pauses here until every owed result has come.
		drain();

		send_idle_pct = 55;
		recv_idle_pct = 30;
		random_phase(70);

		send_idle_pct = 0;
		recv_idle_pct = 0;
		random_phase(70);
		drain();

		$display("Covered %0d input transfers and %0d result transfers over",
			n_sent, sb.n_checked);
		$display("start rows, path sums, marginal rows, overflow and stalls.");
		if (sb.n_errors == 0 && sb.owed.size() == 0) begin
			$display("Regression PASS");
		end else begin
			$display("Regression FAIL");
		end
		$finish;
	end

endmodule
